/* rtl/core/rpp_pkg.sv */
// ----------------------------------------------------------------------------
// rpp_pkg: shared constants, tables and types
// Widths, phase conversion constants, arctangent table and the structs that
// travel down the CORDIC row.
// ----------------------------------------------------------------------------
`default_nettype none

package rpp_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int CORDIC_STAGES = 16;

  localparam int ANGLE_W     = 32;                  // angle field and phase
  localparam int K_W         = 30;                  // phase scale constants
  localparam int PH_PROD_W   = 48;                  // kept bits of angle * K
  localparam int VEC_W       = 34;                  // CORDIC x, y (Q4.30) and z
  localparam int DIFF_W      = COORD_WIDTH + 1;     // point minus pivot
  localparam int PROD_W      = DIFF_W + VEC_W;      // |d| * |t|
  localparam int FRAC_W      = 30;                  // trig fraction bits
  localparam int RND_W       = PROD_W - FRAC_W;     // rounded magnitude
  localparam int SUM_W       = RND_W + 3;           // two terms plus pivot
  localparam int STAGE_IDX_W = 5;                   // index into angle table

  localparam logic [K_W-1:0] RAD_TO_PHASE = K_W'(683565276);
  localparam logic [K_W-1:0] DEG_TO_PHASE = K_W'(11930465);

  localparam logic signed [VEC_W-1:0] CORDIC_START = VEC_W'(34'h26DD3B6A);

  // arctan(2^-i) in phase units, 2^32 per turn
  localparam logic [ANGLE_W-1:0] STAGE_ANGLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } cordic_t;

  // side data that rides along with the rotator
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    coord_t                   px;
    coord_t                   py;
    coord_t                   pz;
    logic                     flip;
  } carry_t;

endpackage

`default_nettype wire

/* rtl/core/rpp_in_if.sv */
// ----------------------------------------------------------------------------
// rpp_in_if: point and pivot input channel
// valid/ready channel carrying one point, pivot and angle per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpp_in_if;
  import rpp_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pivot_x;
  coord_t pivot_y;
  logic signed [ANGLE_W-1:0] turn_angle;
  logic   angle_is_degrees;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;

  modport source (
    output valid, pivot_x, pivot_y, turn_angle, angle_is_degrees,
           point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, pivot_x, pivot_y, turn_angle, angle_is_degrees,
           point_x, point_y, point_z,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/rpp_out_if.sv */
// ----------------------------------------------------------------------------
// rpp_out_if: rotated point output channel
// valid/ready channel carrying one rotated point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpp_out_if;
  import rpp_pkg::*;

  logic   valid;
  logic   ready;
  coord_t rotated_x;
  coord_t rotated_y;
  coord_t rotated_z;
  logic   saturated;

  modport source (
    output valid, rotated_x, rotated_y, rotated_z, saturated,
    input  ready
  );

  modport sink (
    input  valid, rotated_x, rotated_y, rotated_z, saturated,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/rpp_front.sv */
// ----------------------------------------------------------------------------
// rpp_front: angle to phase, quadrant fold, offset from pivot
// Two stages: scale multiply and offsets, then rounding, fold and CORDIC seed.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_front (
  input  wire logic       clk,
  input  wire logic       rst,
  rpp_in_if.sink          up,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output rpp_pkg::cordic_t dn_vec,
  output rpp_pkg::carry_t  dn_carry
);
  import rpp_pkg::*;

  // stage 0 registers
  logic                          s0_valid;
  logic                          s0_ready;
  logic [PH_PROD_W-1:0]          s0_prod;
  carry_t                        s0_carry;

  logic [K_W-1:0]                k_sel;
  logic signed [ANGLE_W+K_W:0]   prod_full;
  logic [PH_PROD_W-1:0]          ph_sum;
  logic [ANGLE_W-1:0]            phase;
  logic                          fold;
  logic [ANGLE_W-1:0]            phase_f;
  carry_t                        carry_next;
  carry_t                        carry_out;

  assign s0_ready = !dn_valid || dn_ready;
  assign up.ready = !s0_valid || s0_ready;

  always_comb begin
    k_sel     = up.angle_is_degrees ? DEG_TO_PHASE : RAD_TO_PHASE;
    prod_full = up.turn_angle * $signed({1'b0, k_sel});
    carry_next.dx   = {up.point_x[COORD_WIDTH-1], up.point_x}
                    - {up.pivot_x[COORD_WIDTH-1], up.pivot_x};
    carry_next.dy   = {up.point_y[COORD_WIDTH-1], up.point_y}
                    - {up.pivot_y[COORD_WIDTH-1], up.pivot_y};
    carry_next.px   = up.pivot_x;
    carry_next.py   = up.pivot_y;
    carry_next.pz   = up.point_z;
    carry_next.flip = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (up.ready) begin
      s0_valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      s0_prod  <= prod_full[PH_PROD_W-1:0];
      s0_carry <= carry_next;
    end
  end

  // round to nearest phase, then fold the left half plane by a half turn
  always_comb begin
    ph_sum  = s0_prod + PH_PROD_W'(16'h8000);
    phase   = ph_sum[PH_PROD_W-1:PH_PROD_W-ANGLE_W];
    fold    = phase[ANGLE_W-1] ^ phase[ANGLE_W-2];
    phase_f = {phase[ANGLE_W-1] ^ fold, phase[ANGLE_W-2:0]};
    carry_out      = s0_carry;
    carry_out.flip = fold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (s0_ready) begin
      dn_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && s0_ready) begin
      dn_vec.x <= CORDIC_START;
      dn_vec.y <= '0;
      dn_vec.z <= VEC_W'($signed(phase_f));
      dn_carry <= carry_out;
    end
  end

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> (dn_vec.z[ANGLE_W-1] == dn_vec.z[ANGLE_W-2]))
    else $error("folded phase outside the right half plane");

  a_seed: assert property (@(posedge clk) disable iff (rst)
    dn_valid |-> (dn_vec.x == CORDIC_START && dn_vec.y == '0))
    else $error("CORDIC seed vector corrupted");

endmodule

`default_nettype wire

/* rtl/core/rpp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rpp_cordic_cell: one CORDIC rotation stage
// Rotates by +/- arctan(2^-i) towards zero residual angle, then registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_cordic_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [rpp_pkg::STAGE_IDX_W-1:0]  stage_idx,
  input  wire logic                             up_valid,
  output logic                                  up_ready,
  input  wire rpp_pkg::cordic_t                 up_vec,
  input  wire rpp_pkg::carry_t                  up_carry,
  output logic                                  dn_valid,
  input  wire logic                             dn_ready,
  output rpp_pkg::cordic_t                      dn_vec,
  output rpp_pkg::carry_t                       dn_carry
);
  import rpp_pkg::*;

  logic signed [VEC_W-1:0] shx;
  logic signed [VEC_W-1:0] shy;
  logic signed [VEC_W-1:0] ang;
  cordic_t                 vec_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    shx = up_vec.x >>> stage_idx;
    shy = up_vec.y >>> stage_idx;
    ang = $signed({{(VEC_W-ANGLE_W){1'b0}}, STAGE_ANGLE[stage_idx]});
    if (!up_vec.z[VEC_W-1]) begin
      vec_next.x = up_vec.x - shy;
      vec_next.y = up_vec.y + shx;
      vec_next.z = up_vec.z - ang;
    end else begin
      vec_next.x = up_vec.x + shy;
      vec_next.y = up_vec.y - shx;
      vec_next.z = up_vec.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_vec   <= vec_next;
      dn_carry <= up_carry;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rpp_back.sv */
// ----------------------------------------------------------------------------
// rpp_back: products, pivot add-back and saturation
// Four stages: magnitudes, multiplies, rounding and sums, clamp to output.
// ----------------------------------------------------------------------------
`default_nettype none

module rpp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire rpp_pkg::cordic_t  up_vec,
  input  wire rpp_pkg::carry_t   up_carry,
  rpp_out_if.source              dn
);
  import rpp_pkg::*;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  function automatic logic signed [SUM_W-1:0] round_apply(
    input logic [PROD_W-1:0] p,
    input logic              neg
  );
    logic [PROD_W-1:0]      r;
    logic signed [RND_W:0]  m;
    r = p + (PROD_W'(1) << (FRAC_W - 1));
    m = $signed({1'b0, r[PROD_W-1:FRAC_W]});
    return SUM_W'(neg ? -m : m);
  endfunction

  function automatic logic [DIFF_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic [VEC_W-1:0] mag_t(input logic signed [VEC_W-1:0] v);
    return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
  endfunction

  logic s0_valid, s1_valid, s2_valid;
  logic s0_ready, s1_ready, s2_ready;

  // stage 0: magnitudes and product signs
  logic [DIFF_W-1:0] s0_mdx, s0_mdy;
  logic [VEC_W-1:0]  s0_mc, s0_ms;
  logic              s0_n_xc, s0_n_ys, s0_n_xs, s0_n_yc;
  coord_t            s0_px, s0_py, s0_pz;
  logic              neg_c, neg_s;

  // stage 1: products
  logic [PROD_W-1:0] s1_xc, s1_ys, s1_xs, s1_yc;
  logic              s1_n_xc, s1_n_ys, s1_n_xs, s1_n_yc;
  coord_t            s1_px, s1_py, s1_pz;

  // stage 2: sums of the rounded products
  logic signed [SUM_W-1:0] s2_rx, s2_ry;
  coord_t                  s2_pz;
  logic signed [SUM_W-1:0] rx_next, ry_next;
  logic                    ovf_x, ovf_y;

  assign s2_ready = !dn.valid || dn.ready;
  assign s1_ready = !s2_valid || s2_ready;
  assign s0_ready = !s1_valid || s1_ready;
  assign up_ready = !s0_valid || s0_ready;

  assign neg_c = up_vec.x[VEC_W-1] ^ up_carry.flip;
  assign neg_s = up_vec.y[VEC_W-1] ^ up_carry.flip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      dn.valid <= 1'b0;
    end else begin
      if (up_ready) s0_valid <= up_valid;
      if (s0_ready) s1_valid <= s0_valid;
      if (s1_ready) s2_valid <= s1_valid;
      if (s2_ready) dn.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      s0_mdx  <= mag_d(up_carry.dx);
      s0_mdy  <= mag_d(up_carry.dy);
      s0_mc   <= mag_t(up_vec.x);
      s0_ms   <= mag_t(up_vec.y);
      s0_n_xc <= up_carry.dx[DIFF_W-1] ^ neg_c;
      s0_n_ys <= up_carry.dy[DIFF_W-1] ^ neg_s;
      s0_n_xs <= up_carry.dx[DIFF_W-1] ^ neg_s;
      s0_n_yc <= up_carry.dy[DIFF_W-1] ^ neg_c;
      s0_px   <= up_carry.px;
      s0_py   <= up_carry.py;
      s0_pz   <= up_carry.pz;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && s0_ready) begin
      s1_xc   <= PROD_W'(s0_mdx) * PROD_W'(s0_mc);
      s1_ys   <= PROD_W'(s0_mdy) * PROD_W'(s0_ms);
      s1_xs   <= PROD_W'(s0_mdx) * PROD_W'(s0_ms);
      s1_yc   <= PROD_W'(s0_mdy) * PROD_W'(s0_mc);
      s1_n_xc <= s0_n_xc;
      s1_n_ys <= s0_n_ys;
      s1_n_xs <= s0_n_xs;
      s1_n_yc <= s0_n_yc;
      s1_px   <= s0_px;
      s1_py   <= s0_py;
      s1_pz   <= s0_pz;
    end
  end

  always_comb begin
    rx_next = round_apply(s1_xc, s1_n_xc) - round_apply(s1_ys, s1_n_ys)
            + SUM_W'(s1_px);
    ry_next = round_apply(s1_xs, s1_n_xs) + round_apply(s1_yc, s1_n_yc)
            + SUM_W'(s1_py);
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2_rx <= rx_next;
      s2_ry <= ry_next;
      s2_pz <= s1_pz;
    end
  end

  // out of range when the bits above the coordinate do not all match its sign
  always_comb begin
    ovf_x = (s2_rx[SUM_W-1:COORD_WIDTH-1] != {(SUM_W-COORD_WIDTH+1){s2_rx[SUM_W-1]}});
    ovf_y = (s2_ry[SUM_W-1:COORD_WIDTH-1] != {(SUM_W-COORD_WIDTH+1){s2_ry[SUM_W-1]}});
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      dn.rotated_x <= ovf_x ? (s2_rx[SUM_W-1] ? COORD_MIN : COORD_MAX)
                            : s2_rx[COORD_WIDTH-1:0];
      dn.rotated_y <= ovf_y ? (s2_ry[SUM_W-1] ? COORD_MIN : COORD_MAX)
                            : s2_ry[COORD_WIDTH-1:0];
      dn.rotated_z <= s2_pz;
      dn.saturated <= ovf_x || ovf_y;
    end
  end

  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    (dn.valid && dn.saturated) |->
      (dn.rotated_x == COORD_MAX || dn.rotated_x == COORD_MIN ||
       dn.rotated_y == COORD_MAX || dn.rotated_y == COORD_MIN))
    else $error("saturated flag without a clamped coordinate");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_ready) |=> s2_valid)
    else $error("result lost in the sum stage while the output stalled");

endmodule

`default_nettype wire

/* rtl/core/rotate_point_about_pivot_core.sv */
// ----------------------------------------------------------------------------
// rotate_point_about_pivot_core: rotate a point about a pivot in x-y
// Angle reduction, a row of CORDIC cells for sine and cosine, then the
// offset products, pivot add-back and saturation. z passes through.
// ----------------------------------------------------------------------------
//
//  channel  | dir | contents
//  ---------+-----+------------------------------------------------------
//  pt_in    | in  | pivot_x/y, turn_angle, angle_is_degrees, point_x/y/z
//  pt_out   | out | rotated_x/y/z, saturated
//
//  One transfer per cycle in each direction while pt_out is ready; the
//  whole datapath is a pipeline with a register per stage.
//  The stages are two front stages, one per CORDIC cell and four in the
//  product and clamp path.
//  Each stage holds its own valid bit and is ready when empty or when the
//  stage after it moves, so bubbles are squeezed out during an output stall.
//  Synchronous reset empties every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_point_about_pivot_core (
  input  wire logic  clk,
  input  wire logic  rst,
  rpp_in_if.sink     pt_in,
  rpp_out_if.source  pt_out
);
  import rpp_pkg::*;

  // link k sits between cell k-1 and cell k; link 0 is the front output
  logic    lk_valid [CORDIC_STAGES+1];
  logic    lk_ready [CORDIC_STAGES+1];
  cordic_t lk_vec   [CORDIC_STAGES+1];
  carry_t  lk_carry [CORDIC_STAGES+1];

  // phase scaling, quadrant fold and pivot offsets
  rpp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up       (pt_in),
    .dn_valid (lk_valid[0]),
    .dn_ready (lk_ready[0]),
    .dn_vec   (lk_vec[0]),
    .dn_carry (lk_carry[0])
  );

  // CORDIC row: cell i rotates by arctan(2^-i)
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rpp_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (STAGE_IDX_W'(i)),
      .up_valid  (lk_valid[i]),
      .up_ready  (lk_ready[i]),
      .up_vec    (lk_vec[i]),
      .up_carry  (lk_carry[i]),
      .dn_valid  (lk_valid[i+1]),
      .dn_ready  (lk_ready[i+1]),
      .dn_vec    (lk_vec[i+1]),
      .dn_carry  (lk_carry[i+1])
    );
  end

  // products, add-back and clamp; its last register drives pt_out
  rpp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .up_valid (lk_valid[CORDIC_STAGES]),
    .up_ready (lk_ready[CORDIC_STAGES]),
    .up_vec   (lk_vec[CORDIC_STAGES]),
    .up_carry (lk_carry[CORDIC_STAGES]),
    .dn       (pt_out)
  );

endmodule

`default_nettype wire
